// ----- hw/rtl/bsb_pkg.sv -----
// ============================================================================
// bsb_pkg
// Shared types, widths and helper functions for the B-spline basis/slope core.
// ============================================================================
package bsb_pkg;

   localparam int FRAC_BITS = 16;
   localparam int VAL_W     = FRAC_BITS + 1;
   localparam int SPAN_W    = 10;
   localparam int DEG_W     = 2;
   localparam int WIN       = 8;
   localparam int MAX_DEG   = 3;
   localparam int NCUR      = 2 * MAX_DEG + 1;
   localparam int NLOW      = MAX_DEG + 2;
   localparam int NRES      = MAX_DEG + 1;
   localparam int SLOPE_W   = 32;
   localparam int DIV_STEP  = 4;
   localparam int REC_Q_W   = VAL_W;
   localparam int REC_D_W   = REC_Q_W + VAL_W;
   localparam int SLP_Q_W   = 34;
   localparam int SLP_D_W   = SLP_Q_W + VAL_W;
   localparam int PN_W      = VAL_W + 2;

   localparam logic [VAL_W-1:0]   ONE_Q       = VAL_W'(1) << FRAC_BITS;
   localparam logic [DEG_W-1:0]   DEG_RESET   = DEG_W'(2);
   localparam logic [SLOPE_W-1:0] SLOPE_MAX   = {1'b0, {(SLOPE_W-1){1'b1}}};
   localparam logic [SLOPE_W-1:0] SLOPE_MIN   = {1'b1, {(SLOPE_W-1){1'b0}}};
   localparam logic signed [SLP_Q_W:0] DIFF_MAX = (SLP_Q_W+1)'(SLOPE_MAX);
   localparam logic signed [SLP_Q_W:0] DIFF_MIN = ~DIFF_MAX;

   typedef struct packed {
      logic [VAL_W-1:0]                 u;
      logic [SPAN_W-1:0]                span;
      logic [DEG_W-1:0]                 p;
      logic [WIN-1:0][VAL_W-1:0]        knot;
      logic [NCUR-1:0][VAL_W-1:0]       cur;
      logic [NLOW-1:0][VAL_W-1:0]       lower;
   } ctx_type;

   typedef struct packed {
      logic [NRES-1:0][VAL_W-1:0]       val;
      logic [NRES-1:0][SLOPE_W-1:0]     slope;
      logic [SPAN_W-1:0]                span;
      logic [DEG_W-1:0]                 p;
   } ser_type;

   typedef struct packed {
      logic [REC_D_W-1:0] dvd;
      logic [VAL_W-1:0]   dvs;
   } rec_arg_type;

   typedef struct packed {
      logic [SLP_D_W-1:0] dvd;
      logic [VAL_W-1:0]   dvs;
   } slp_arg_type;

   function automatic logic signed [VAL_W:0] sdiff(input logic [VAL_W-1:0] a,
                                                   input logic [VAL_W-1:0] b);
      return $signed({1'b0, a}) - $signed({1'b0, b});
   endfunction

   // num (clamped to 0..gap) * n + gap/2 over gap; a gap that is not positive yields 0 / 1
   function automatic rec_arg_type rec_arg(input logic signed [VAL_W:0] num,
                                           input logic signed [VAL_W:0] gap,
                                           input logic [VAL_W-1:0]      n);
      logic [VAL_W-1:0]   nc;
      logic [REC_D_W-1:0] prod;
      rec_arg_type        r;
      r.dvd = '0;
      r.dvs = VAL_W'(1);
      if (gap > 0) begin
         if (num < 0) begin
            nc = '0;
         end else if (num > gap) begin
            nc = gap[VAL_W-1:0];
         end else begin
            nc = num[VAL_W-1:0];
         end
         prod  = {{VAL_W{1'b0}}, nc} * {{VAL_W{1'b0}}, n};
         r.dvd = prod + REC_D_W'(gap[VAL_W-1:1]);
         r.dvs = gap[VAL_W-1:0];
      end
      return r;
   endfunction

   // p*n*ONE + gap/2 over gap
   function automatic slp_arg_type slp_arg(input logic signed [VAL_W:0] gap,
                                           input logic [VAL_W-1:0]      n,
                                           input logic [DEG_W-1:0]      p);
      logic [PN_W-1:0] pn;
      slp_arg_type     r;
      r.dvd = '0;
      r.dvs = VAL_W'(1);
      pn = (p[0] ? {2'b00, n} : '0) + (p[1] ? {1'b0, n, 1'b0} : '0);
      if (gap > 0) begin
         r.dvd = SLP_D_W'({pn, {FRAC_BITS{1'b0}}}) + SLP_D_W'(gap[VAL_W-1:1]);
         r.dvs = gap[VAL_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [VAL_W-1:0] sat_one(input logic [VAL_W-1:0] a,
                                                input logic [VAL_W-1:0] b);
      logic [VAL_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > {1'b0, ONE_Q}) ? ONE_Q : s[VAL_W-1:0];
   endfunction

   function automatic logic [SLOPE_W-1:0] sat_slope(input logic [SLP_Q_W-1:0] t0,
                                                    input logic [SLP_Q_W-1:0] t1);
      logic signed [SLP_Q_W:0] diff;
      diff = $signed({1'b0, t0}) - $signed({1'b0, t1});
      if (diff > DIFF_MAX) begin
         return SLOPE_MAX;
      end else if (diff < DIFF_MIN) begin
         return SLOPE_MIN;
      end
      return diff[SLOPE_W-1:0];
   endfunction

endpackage

// ----- hw/rtl/bsb_if.sv -----
// ============================================================================
// bsb_if
// Valid/ready channels of the B-spline basis/slope core.
// ============================================================================
interface bsb_req_if import bsb_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [VAL_W-1:0]    param_value;
   logic [SPAN_W-1:0]   span_index;
   logic [VAL_W-1:0]    knot_0;
   logic [VAL_W-1:0]    knot_1;
   logic [VAL_W-1:0]    knot_2;
   logic [VAL_W-1:0]    knot_3;
   logic [VAL_W-1:0]    knot_4;
   logic [VAL_W-1:0]    knot_5;
   logic [VAL_W-1:0]    knot_6;
   logic [VAL_W-1:0]    knot_7;

   modport source (output valid, param_value, span_index, knot_0, knot_1, knot_2,
                   knot_3, knot_4, knot_5, knot_6, knot_7, input ready);
   modport sink   (input valid, param_value, span_index, knot_0, knot_1, knot_2,
                   knot_3, knot_4, knot_5, knot_6, knot_7, output ready);
endinterface

interface bsb_rsp_if import bsb_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [VAL_W-1:0]    basis_value;
   logic [SLOPE_W-1:0]  basis_slope;
   logic [SPAN_W-1:0]   basis_number;
   logic                last;

   modport source (output valid, basis_value, basis_slope, basis_number, last,
                   input ready);
   modport sink   (input valid, basis_value, basis_slope, basis_number, last,
                   output ready);
endinterface

// ----- hw/rtl/bspline_basis_and_slope_core.sv -----
// ============================================================================
// bspline_basis_and_slope_core
// Cox-de Boor B-spline basis values and first derivatives for one knot span.
// ============================================================================
// Usage:
//  - req_chan carries one transaction per evaluation point: the parameter
//    value, its span index and the eight-knot local window (Q16 each).
//  - rsp_chan returns degree+1 transactions per request, one per nonzero
//    basis function, with last set on the final one.
//  - csr_we/csr_wdata write the degree (0 acts as 1). Write only while idle.
//  - The results of a request follow one another, one per cycle while
//    rsp_chan.ready holds.
//  - A new request is taken only once the single result port has handed
//    out the last result of the one before; while the serializer is empty
//    the pipeline itself takes a request every cycle.
//  - The pipeline is three recurrence levels (multiply, 5-stage divider,
//    sum) plus a slope level (9-stage divider) and a result serializer.
//  - Reset (synchronous, active high) empties the pipeline and sets the
//    degree to 2.
//  - When rsp_chan stalls, the serializer holds and the whole pipeline
//    freezes in place; req_chan.ready drops until it can advance again.
// ============================================================================
module bspline_basis_and_slope_core import bsb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [DEG_W-1:0]  csr_wdata,
   bsb_req_if.sink           req_chan,
   bsb_rsp_if.source         rsp_chan
);

   localparam int REC_LAT = (REC_Q_W + DIV_STEP - 1) / DIV_STEP;
   localparam int SLP_LAT = (SLP_Q_W + DIV_STEP - 1) / DIV_STEP;

   // ---------------------------------------------------------------------
   // Degree register
   // ---------------------------------------------------------------------
   logic [DEG_W-1:0] degree_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= DEG_RESET;
      end else if (csr_we) begin
         degree_ff <= csr_wdata;
      end
   end

   // Global advance: every stage moves together when the serializer frees up
   logic adv;

   // ---------------------------------------------------------------------
   // Input stage: degree-0 indicators of the half-open knot intervals
   // ---------------------------------------------------------------------
   ctx_type ctx_in;
   ctx_type lvl_ctx_ff [0:MAX_DEG];
   logic    lvl_v_ff   [0:MAX_DEG];

   always_comb begin
      logic hit;
      ctx_in.u       = req_chan.param_value;
      ctx_in.span    = req_chan.span_index;
      ctx_in.p       = (degree_ff == '0) ? DEG_W'(1) : degree_ff;
      ctx_in.knot[0] = req_chan.knot_0;
      ctx_in.knot[1] = req_chan.knot_1;
      ctx_in.knot[2] = req_chan.knot_2;
      ctx_in.knot[3] = req_chan.knot_3;
      ctx_in.knot[4] = req_chan.knot_4;
      ctx_in.knot[5] = req_chan.knot_5;
      ctx_in.knot[6] = req_chan.knot_6;
      ctx_in.knot[7] = req_chan.knot_7;
      ctx_in.lower   = '0;
      for (int m = 0; m < NCUR; m++) begin
         hit = (ctx_in.knot[m] <= ctx_in.u) && (ctx_in.u < ctx_in.knot[m+1]);
         // domain end closes the span interval on the right
         if ((ctx_in.u == ONE_Q) && (m == int'(ctx_in.p)) &&
             (ctx_in.knot[m] < ctx_in.knot[m+1]) &&
             (ctx_in.knot[m] <= ctx_in.u) && (ctx_in.u <= ctx_in.knot[m+1])) begin
            hit = 1'b1;
         end
         if (m > 2 * int'(ctx_in.p)) begin
            hit = 1'b0;
         end
         ctx_in.cur[m] = hit ? ONE_Q : '0;
      end
   end

   assign req_chan.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         lvl_v_ff[0] <= 1'b0;
      end else if (adv) begin
         lvl_v_ff[0] <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lvl_ctx_ff[0] <= ctx_in;
      end
   end

   // ---------------------------------------------------------------------
   // Recurrence levels d = 1..MAX_DEG; a level above the degree passes through
   // ---------------------------------------------------------------------
   for (genvar d = 1; d <= MAX_DEG; d++) begin : gen_lvl
      logic [VAL_W-1:0] qa [NCUR];
      logic [VAL_W-1:0] qb [NCUR];
      ctx_type          cp_ff [0:REC_LAT];
      logic             cpv_ff [0:REC_LAT];
      ctx_type          lvl_in;

      for (genvar m = 0; m < NCUR; m++) begin : gen_term
         localparam int IA = (m + d > WIN - 1) ? (WIN - 1) : (m + d);
         localparam int IB = (m + d + 1 > WIN - 1) ? (WIN - 1) : (m + d + 1);
         localparam int IC = (m + 1 < NCUR) ? (m + 1) : (NCUR - 1);

         rec_arg_type      a_in, b_in, a_ff, b_ff;
         logic [VAL_W-1:0] n_b;

         assign n_b  = (m + 1 < NCUR) ? lvl_ctx_ff[d-1].cur[IC] : '0;
         assign a_in = rec_arg(sdiff(lvl_ctx_ff[d-1].u, lvl_ctx_ff[d-1].knot[m]),
                               sdiff(lvl_ctx_ff[d-1].knot[IA], lvl_ctx_ff[d-1].knot[m]),
                               lvl_ctx_ff[d-1].cur[m]);
         assign b_in = rec_arg(sdiff(lvl_ctx_ff[d-1].knot[IB], lvl_ctx_ff[d-1].u),
                               sdiff(lvl_ctx_ff[d-1].knot[IB], lvl_ctx_ff[d-1].knot[m+1]),
                               n_b);

         always_ff @(posedge clock) begin
            if (adv) begin
               a_ff <= a_in;
               b_ff <= b_in;
            end
         end

         bsb_div #(.DVS_W(VAL_W), .QUOT_W(REC_Q_W), .STEP(DIV_STEP)) u_div_a (
            .clock    (clock),
            .enable   (adv),
            .dividend (a_ff.dvd),
            .divisor  (a_ff.dvs),
            .quotient (qa[m])
         );

         bsb_div #(.DVS_W(VAL_W), .QUOT_W(REC_Q_W), .STEP(DIV_STEP)) u_div_b (
            .clock    (clock),
            .enable   (adv),
            .dividend (b_ff.dvd),
            .divisor  (b_ff.dvs),
            .quotient (qb[m])
         );
      end

      // context rides alongside the dividers
      always_ff @(posedge clock) begin
         if (reset) begin
            for (int i = 0; i <= REC_LAT; i++) begin
               cpv_ff[i] <= 1'b0;
            end
         end else if (adv) begin
            cpv_ff[0] <= lvl_v_ff[d-1];
            for (int i = 1; i <= REC_LAT; i++) begin
               cpv_ff[i] <= cpv_ff[i-1];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            cp_ff[0] <= lvl_ctx_ff[d-1];
            for (int i = 1; i <= REC_LAT; i++) begin
               cp_ff[i] <= cp_ff[i-1];
            end
         end
      end

      // at level p keep the incoming terms as lower; sum, saturate, drop terms beyond the triangle
      always_comb begin
         lvl_in = cp_ff[REC_LAT];
         if (int'(cp_ff[REC_LAT].p) == d) begin
            for (int i = 0; i < NLOW; i++) begin
               lvl_in.lower[i] = cp_ff[REC_LAT].cur[i];
            end
         end
         if (int'(cp_ff[REC_LAT].p) >= d) begin
            for (int m = 0; m < NCUR; m++) begin
               lvl_in.cur[m] = (m + d <= 2 * int'(cp_ff[REC_LAT].p)) ?
                               sat_one(qa[m], qb[m]) : '0;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            lvl_v_ff[d] <= 1'b0;
         end else if (adv) begin
            lvl_v_ff[d] <= cpv_ff[REC_LAT];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            lvl_ctx_ff[d] <= lvl_in;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Slope terms T(i) = p*lower[i]/(k[i+p]-k[i]); slope(j) = T(j) - T(j+1)
   // ---------------------------------------------------------------------
   slp_arg_type       s_in  [NLOW];
   slp_arg_type       s_ff  [NLOW];
   logic [SLP_Q_W-1:0] sq   [NLOW];
   ctx_type           sctx_ff [0:SLP_LAT];
   logic              sv_ff   [0:SLP_LAT];

   always_comb begin
      logic [2:0] idx;
      for (int i = 0; i < NLOW; i++) begin
         idx     = 3'(i + int'(lvl_ctx_ff[MAX_DEG].p));
         s_in[i] = slp_arg(sdiff(lvl_ctx_ff[MAX_DEG].knot[idx], lvl_ctx_ff[MAX_DEG].knot[i]),
                           lvl_ctx_ff[MAX_DEG].lower[i], lvl_ctx_ff[MAX_DEG].p);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NLOW; i++) begin
            s_ff[i] <= s_in[i];
         end
      end
   end

   for (genvar i = 0; i < NLOW; i++) begin : gen_slp
      bsb_div #(.DVS_W(VAL_W), .QUOT_W(SLP_Q_W), .STEP(DIV_STEP)) u_div_s (
         .clock    (clock),
         .enable   (adv),
         .dividend (s_ff[i].dvd),
         .divisor  (s_ff[i].dvs),
         .quotient (sq[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= SLP_LAT; i++) begin
            sv_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         sv_ff[0] <= lvl_v_ff[MAX_DEG];
         for (int i = 1; i <= SLP_LAT; i++) begin
            sv_ff[i] <= sv_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sctx_ff[0] <= lvl_ctx_ff[MAX_DEG];
         for (int i = 1; i <= SLP_LAT; i++) begin
            sctx_ff[i] <= sctx_ff[i-1];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Serializer: holds one request's results and hands them out in order
   // ---------------------------------------------------------------------
   ser_type           ser_in;
   ser_type           ser_ff;
   logic              ser_v_ff;
   logic [DEG_W-1:0]  ser_idx_ff;
   logic              ser_last;
   logic              out_load;

   logic              rsp_valid_ff;
   logic [VAL_W-1:0]  rsp_value_ff;
   logic [SLOPE_W-1:0] rsp_slope_ff;
   logic [SPAN_W-1:0] rsp_number_ff;
   logic              rsp_last_ff;

   always_comb begin
      ser_in.span = sctx_ff[SLP_LAT].span;
      ser_in.p    = sctx_ff[SLP_LAT].p;
      for (int j = 0; j < NRES; j++) begin
         ser_in.val[j]   = sctx_ff[SLP_LAT].cur[j];
         // domain end: last basis is one, the others zero
         if (sctx_ff[SLP_LAT].u == ONE_Q) begin
            ser_in.val[j] = (j == int'(sctx_ff[SLP_LAT].p)) ? ONE_Q : '0;
         end
         ser_in.slope[j] = sat_slope(sq[j], sq[j+1]);
      end
   end

   assign ser_last = (ser_idx_ff == ser_ff.p);
   assign out_load = ser_v_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign adv      = !ser_v_ff || (out_load && ser_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_v_ff   <= 1'b0;
         ser_idx_ff <= '0;
      end else begin
         if (adv) begin
            ser_v_ff <= sv_ff[SLP_LAT];
         end
         if (out_load) begin
            ser_idx_ff <= ser_last ? '0 : ser_idx_ff + DEG_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ser_ff <= ser_in;
      end
   end

   // ---------------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_chan.ready) begin
         rsp_valid_ff <= ser_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_value_ff  <= ser_ff.val[ser_idx_ff];
         rsp_slope_ff  <= ser_ff.slope[ser_idx_ff];
         rsp_number_ff <= ser_ff.span + SPAN_W'(ser_idx_ff) - SPAN_W'(ser_ff.p);
         rsp_last_ff   <= ser_last;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.basis_value  = rsp_value_ff;
   assign rsp_chan.basis_slope  = rsp_slope_ff;
   assign rsp_chan.basis_number = rsp_number_ff;
   assign rsp_chan.last         = rsp_last_ff;

`ifndef SYNTH
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      ser_v_ff |-> (ser_idx_ff <= ser_ff.p))
      else $error("serializer index past degree");

   a_deg_nonzero: assert property (@(posedge clock) disable iff (reset)
      ser_v_ff |-> (ser_ff.p != '0))
      else $error("zero degree reached serializer");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (out_load && ser_last) |-> adv)
      else $error("final result emitted without pipeline advance");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (!adv) |=> (ser_v_ff && $stable(ser_ff)))
      else $error("serializer contents changed during stall");
`endif

endmodule

// ----- hw/rtl/bsb_div.sv -----
// ============================================================================
// bsb_div
// Pipelined restoring divider, STEP quotient bits per register stage (fewer in the last
// stage when QUOT_W is not a multiple of STEP).
module bsb_div #(
   parameter int DVS_W  = 17,
   parameter int QUOT_W = 17,
   parameter int STEP   = 4
) (
   input  logic                      clock,
   input  logic                      enable,
   input  logic [QUOT_W+DVS_W-1:0]   dividend,
   input  logic [DVS_W-1:0]          divisor,
   output logic [QUOT_W-1:0]         quotient
);

   localparam int NSTG = (QUOT_W + STEP - 1) / STEP;

   logic [DVS_W-1:0]  rem_ff  [NSTG];
   logic [QUOT_W-1:0] rest_ff [NSTG];
   logic [QUOT_W-1:0] quot_ff [NSTG];
   logic [DVS_W-1:0]  dvs_ff  [NSTG];

   for (genvar s = 0; s < NSTG; s++) begin : gen_stg
      localparam int NB = (QUOT_W - s * STEP < STEP) ? (QUOT_W - s * STEP) : STEP;

      logic [DVS_W-1:0]  src_rem;
      logic [QUOT_W-1:0] src_rest;
      logic [QUOT_W-1:0] src_quot;
      logic [DVS_W-1:0]  src_dvs;
      logic [DVS_W-1:0]  rem_in;
      logic [QUOT_W-1:0] rest_in;
      logic [QUOT_W-1:0] quot_in;

      if (s == 0) begin : g_first
         assign src_rem  = dividend[QUOT_W+DVS_W-1:QUOT_W];
         assign src_rest = dividend[QUOT_W-1:0];
         assign src_quot = '0;
         assign src_dvs  = divisor;
      end else begin : g_next
         assign src_rem  = rem_ff[s-1];
         assign src_rest = rest_ff[s-1];
         assign src_quot = quot_ff[s-1];
         assign src_dvs  = dvs_ff[s-1];
      end

      always_comb begin
         logic [DVS_W:0] r2;
         rem_in  = src_rem;
         rest_in = src_rest;
         quot_in = src_quot;
         for (int b = 0; b < NB; b++) begin
            r2      = {rem_in, rest_in[QUOT_W-1]};
            rest_in = {rest_in[QUOT_W-2:0], 1'b0};
            if (r2 >= {1'b0, src_dvs}) begin
               r2      = r2 - {1'b0, src_dvs};
               quot_in = {quot_in[QUOT_W-2:0], 1'b1};
            end else begin
               quot_in = {quot_in[QUOT_W-2:0], 1'b0};
            end
            rem_in = r2[DVS_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[s]  <= rem_in;
            rest_ff[s] <= rest_in;
            quot_ff[s] <= quot_in;
            dvs_ff[s]  <= src_dvs;
         end
      end
   end

   assign quotient = quot_ff[NSTG-1];

endmodule
